/* design/pcgp_pkg.sv */
package pcgp_pkg;

	// field widths
	localparam int COORD_W = 24;
	localparam int INTEN_W = 16;
	localparam int CELL_W  = 8;
	localparam int RC_W    = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	// action codes
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_POINT = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_Z_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Z_HIGH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FREE_THR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FREE_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OCC_STEP  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FILL      = 3'd5;

	// register reset values
	localparam logic signed [COORD_W-1:0] RST_Z_LOW  = 24'sd400;
	localparam logic signed [COORD_W-1:0] RST_Z_HIGH = 24'sd1800;
	localparam logic [INTEN_W-1:0] RST_FREE_THR  = 16'd800;
	localparam logic [CELL_W-1:0]  RST_FREE_STEP = 8'd9;
	localparam logic [CELL_W-1:0]  RST_OCC_STEP  = 8'd27;
	localparam logic [CELL_W-1:0]  RST_FILL      = 8'd127;

	// grid value after reset
	localparam logic [CELL_W-1:0] GRID_RST_VAL = 8'd127;
	localparam logic [CELL_W-1:0] CELL_MAX     = 8'd255;

	// cell size 200 mm: offsets at or beyond the cap clamp whatever the grid size
	// below the cap, m/200 = floor((m>>3) * MAGIC >> 20), exact for m>>3 < 25600
	localparam int MAG_W   = 18;
	localparam int N_W     = 15;
	localparam int M_W     = 16;
	localparam logic [MAG_W-1:0] SAT_MM = 18'd204800;
	localparam logic [M_W-1:0]   MAGIC  = 16'd41944;
	localparam int PROD_W  = N_W + M_W;
	localparam int Q_SHIFT = 20;
	localparam int Q_W     = 11;
	localparam logic [Q_W-1:0] Q_SAT = 11'd1024;
	localparam int IDX_CALC_W = 12;

	typedef struct packed {
		logic signed [COORD_W-1:0] z_low;
		logic signed [COORD_W-1:0] z_high;
		logic [INTEN_W-1:0]        free_thr;
		logic [CELL_W-1:0]         free_step;
		logic [CELL_W-1:0]         occ_step;
		logic [CELL_W-1:0]         fill_level;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_PT_S1,
		ST_PT_S2,
		ST_PT_ADDR,
		ST_PT_READ,
		ST_PT_WRITE,
		ST_RD_READ,
		ST_RD_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic load_start;
		logic step_s1;
		logic step_s2;
		logic calc_addr;
		logic rd_pt;
		logic rd_cell;
		logic wr_pt;
		logic fill_wr;
		logic strobe;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fill_last;
	} status_t;

endpackage

/* design/pcgp_cfg.sv */
module pcgp_cfg
	import pcgp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign cfg       = regs_q;

	// register file, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.z_low      <= RST_Z_LOW;
			regs_q.z_high     <= RST_Z_HIGH;
			regs_q.free_thr   <= RST_FREE_THR;
			regs_q.free_step  <= RST_FREE_STEP;
			regs_q.occ_step   <= RST_OCC_STEP;
			regs_q.fill_level <= RST_FILL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_Z_LOW:     regs_q.z_low      <= $signed(cfg_data);
				REG_Z_HIGH:    regs_q.z_high     <= $signed(cfg_data);
				REG_FREE_THR:  regs_q.free_thr   <= cfg_data[INTEN_W-1:0];
				REG_FREE_STEP: regs_q.free_step  <= cfg_data[CELL_W-1:0];
				REG_OCC_STEP:  regs_q.occ_step   <= cfg_data[CELL_W-1:0];
				REG_FILL:      regs_q.fill_level <= cfg_data[CELL_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

/* design/pcgp_ctrl.sv */
module pcgp_ctrl
	import pcgp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	output logic       busy,
	output cmd_t       cmd,
	input  status_t    status
);

	state_t state_q, state_d;

	// state register, reset begins with a grid clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (action)
						ACT_START: state_d = ST_FILL;
						ACT_POINT: state_d = ST_PT_S1;
						ACT_READ:  state_d = ST_RD_READ;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_FILL: begin
				if (status.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_PT_S1:    state_d = ST_PT_S2;
			ST_PT_S2:    state_d = ST_PT_ADDR;
			ST_PT_ADDR:  state_d = ST_PT_READ;
			ST_PT_READ:  state_d = ST_PT_WRITE;
			ST_PT_WRITE: state_d = ST_IDLE;
			ST_RD_READ:  state_d = ST_RD_OUT;
			ST_RD_OUT:   state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy            = 1'b0;
				cmd.load        = start;
				cmd.load_start  = start && (action == ACT_START);
			end
			ST_FILL:     cmd.fill_wr   = 1'b1;
			ST_PT_S1:    cmd.step_s1   = 1'b1;
			ST_PT_S2:    cmd.step_s2   = 1'b1;
			ST_PT_ADDR:  cmd.calc_addr = 1'b1;
			ST_PT_READ:  cmd.rd_pt     = 1'b1;
			ST_PT_WRITE: cmd.wr_pt     = 1'b1;
			ST_RD_READ:  cmd.rd_cell   = 1'b1;
			ST_RD_OUT:   cmd.strobe    = 1'b1;
			default: begin
			end
		endcase
	end

endmodule

/* design/pcgp_dp.sv */
module pcgp_dp
	import pcgp_pkg::*;
#(
	parameter int GRID_SIDE = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output status_t                   status,
	input  cfg_t                      cfg,
	input  logic signed [COORD_W-1:0] x_mm,
	input  logic signed [COORD_W-1:0] y_mm,
	input  logic signed [COORD_W-1:0] z_mm,
	input  logic [INTEN_W-1:0]        intensity,
	input  logic [RC_W-1:0]           read_row,
	input  logic [RC_W-1:0]           read_col,
	output logic                      done,
	output logic [CELL_W-1:0]         cell_value
);

	localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int IDX_W  = $clog2(GRID_SIDE);
	localparam logic signed [IDX_CALC_W-1:0] HALF = IDX_CALC_W'(GRID_SIDE / 2);
	localparam logic signed [IDX_CALC_W-1:0] IDX_MAX = IDX_CALC_W'(GRID_SIDE - 1);

	// request fields
	logic signed [COORD_W-1:0] x_q, y_q, z_q;
	logic [INTEN_W-1:0]        inten_q;
	logic [RC_W-1:0]           row_q, col_q;

	// frame state
	logic signed [COORD_W-1:0] cx_q, cy_q;
	logic [CELL_W-1:0]         fill_val_q;
	logic [ADDR_W-1:0]         fill_cnt_q;

	// point pipeline
	logic          z_ok_s1, free_s1;
	logic          neg_x_s1, neg_y_s1, sat_x_s1, sat_y_s1;
	logic [N_W-1:0] n_x_s1, n_y_s1;
	logic          neg_x_s2, neg_y_s2;
	logic [Q_W-1:0] q_x_s2, q_y_s2;
	logic [ADDR_W-1:0] addr_q;

	// memory
	logic [CELL_W-1:0] grid_mem [DEPTH];
	logic [CELL_W-1:0] rd_data_q;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] wr_addr, rd_addr, cell_addr;
	logic [CELL_W-1:0] wr_data, upd_val;
	logic              in_range;

	// signed offset from centre, split into sign, saturation and scaled magnitude
	function automatic logic [MAG_W+N_W+1:0] split_off(logic signed [COORD_W-1:0] p,
			logic signed [COORD_W-1:0] c);
		logic signed [COORD_W:0] d;
		logic [COORD_W:0]        a;
		logic                    neg, sat;
		d   = (COORD_W+1)'(p) - (COORD_W+1)'(c);
		neg = d[COORD_W];
		a   = neg ? (COORD_W+1)'(-d) : (COORD_W+1)'(d);
		sat = (a[COORD_W-1:0] >= COORD_W'(SAT_MM));
		return {neg, sat, {MAG_W{1'b0}}, a[MAG_W-1:3]};
	endfunction

	// quotient by 200 through the reciprocal
	function automatic logic [Q_W-1:0] quot(logic [N_W-1:0] n, logic sat);
		logic [PROD_W-1:0] p;
		p = PROD_W'(n) * PROD_W'(MAGIC);
		return sat ? Q_SAT : Q_W'(p >> Q_SHIFT);
	endfunction

	// grid index from quotient, clamped to the edge
	function automatic logic [IDX_W-1:0] to_idx(logic [Q_W-1:0] q, logic neg);
		logic signed [IDX_CALC_W-1:0] t;
		t = neg ? HALF - $signed(IDX_CALC_W'(q)) : HALF + $signed(IDX_CALC_W'(q));
		if (t < 0) begin
			return '0;
		end else if (t > IDX_MAX) begin
			return IDX_W'(IDX_MAX);
		end
		return IDX_W'(t);
	endfunction

	logic [MAG_W+N_W+1:0] off_x, off_y;
	assign off_x = split_off(x_q, cx_q);
	assign off_y = split_off(y_q, cy_q);

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= x_mm;
			y_q     <= y_mm;
			z_q     <= z_mm;
			inten_q <= intensity;
			row_q   <= read_row;
			col_q   <= read_col;
		end
	end

	// centre and fill value, latched by a frame start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q       <= '0;
			cy_q       <= '0;
			fill_val_q <= GRID_RST_VAL;
		end else if (cmd.load_start) begin
			cx_q       <= x_mm;
			cy_q       <= y_mm;
			fill_val_q <= cfg.fill_level;
		end
	end

	// fill sweep counter, wraps to zero at the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q <= '0;
		end else if (cmd.fill_wr) begin
			fill_cnt_q <= status.fill_last ? '0 : fill_cnt_q + 1'b1;
		end
	end

	assign status.fill_last = (32'(fill_cnt_q) == 32'(DEPTH - 1));

	// stage 1: height window, intensity class, offsets
	always_ff @(posedge clk) begin
		if (cmd.step_s1) begin
			z_ok_s1  <= (z_q > cfg.z_low) && (z_q < cfg.z_high);
			free_s1  <= (inten_q < cfg.free_thr);
			neg_x_s1 <= off_x[MAG_W+N_W+1];
			sat_x_s1 <= off_x[MAG_W+N_W];
			n_x_s1   <= off_x[N_W-1:0];
			neg_y_s1 <= off_y[MAG_W+N_W+1];
			sat_y_s1 <= off_y[MAG_W+N_W];
			n_y_s1   <= off_y[N_W-1:0];
		end
	end

	// stage 2: reciprocal multiply
	always_ff @(posedge clk) begin
		if (cmd.step_s2) begin
			q_x_s2   <= quot(n_x_s1, sat_x_s1);
			q_y_s2   <= quot(n_y_s1, sat_y_s1);
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
		end
	end

	// stage 3: clamped cell address
	always_ff @(posedge clk) begin
		if (cmd.calc_addr) begin
			addr_q <= ADDR_W'(32'(to_idx(q_y_s2, neg_y_s2)) * 32'(GRID_SIDE)
				+ 32'(to_idx(q_x_s2, neg_x_s2)));
		end
	end

	// read request address
	assign in_range  = (32'(row_q) < 32'(GRID_SIDE)) && (32'(col_q) < 32'(GRID_SIDE));
	assign cell_addr = ADDR_W'(32'(row_q) * 32'(GRID_SIDE) + 32'(col_q));

	// saturating cell update
	always_comb begin
		logic [CELL_W:0] sum;
		sum = (CELL_W+1)'(rd_data_q) + (CELL_W+1)'(cfg.free_step);
		if (free_s1) begin
			upd_val = sum[CELL_W] ? CELL_MAX : sum[CELL_W-1:0];
		end else begin
			upd_val = (rd_data_q >= cfg.occ_step) ? rd_data_q - cfg.occ_step : '0;
		end
	end

	// memory port selection
	assign mem_we  = cmd.fill_wr || (cmd.wr_pt && z_ok_s1);
	assign wr_addr = cmd.fill_wr ? fill_cnt_q : addr_q;
	assign wr_data = cmd.fill_wr ? fill_val_q : upd_val;
	assign mem_re  = cmd.rd_pt || cmd.rd_cell;
	assign rd_addr = cmd.rd_cell ? cell_addr : addr_q;

	// grid memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rd_data_q <= grid_mem[rd_addr];
		end
	end

	// result
	assign done       = cmd.strobe;
	assign cell_value = in_range ? rd_data_q : '0;

endmodule

/* design/point_cloud_grid_projector_unit.sv */
// channel   | signals                                              | handshake
// ----------+------------------------------------------------------+------------------------
// request   | action x_mm y_mm z_mm intensity read_row read_col    | start && !busy
// result    | cell_value                                           | done, one cycle
// config    | cfg_index cfg_data                                   | cfg_valid && cfg_ready
//
// a point request runs through the offset, reciprocal multiply, address, grid read and
// grid write steps; a read request runs through a grid read and an output step, done in the last
// a frame start and the reset each sweep the grid one cell a cycle through the
// single write port with busy high, reset filling 127
// cfg_ready is always high; results cannot be stalled and appear only on reads
module point_cloud_grid_projector_unit
	import pcgp_pkg::*;
#(
	parameter int GRID_SIDE = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                action,
	input  logic signed [COORD_W-1:0] x_mm,
	input  logic signed [COORD_W-1:0] y_mm,
	input  logic signed [COORD_W-1:0] z_mm,
	input  logic [INTEN_W-1:0]        intensity,
	input  logic [RC_W-1:0]           read_row,
	input  logic [RC_W-1:0]           read_col,
	output logic                      done,
	output logic [CELL_W-1:0]         cell_value,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DAT_W-1:0]      cfg_data
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	// configuration registers
	pcgp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer
	pcgp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	// projection datapath and grid memory
	pcgp_dp #(
		.GRID_SIDE (GRID_SIDE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg        (cfg),
		.x_mm       (x_mm),
		.y_mm       (y_mm),
		.z_mm       (z_mm),
		.intensity  (intensity),
		.read_row   (read_row),
		.read_col   (read_col),
		.done       (done),
		.cell_value (cell_value)
	);

endmodule
